// ===== design/fwpf_pkg.sv =====
// Shared types and constants for the firmware image packet framer.
// No dependencies; used by every module in design/.
`default_nettype none
package fwpf_pkg;

	localparam int PACKET_BYTES = 128;
	localparam int POS_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HDR_CMD = 8'hbf;
	localparam logic [7:0] HDR_PAD = 8'h00;
	localparam logic [15:0] TAIL_ADDR = 16'h6ffa;
	localparam logic [14:0] TRAILER_BYTES = 15'd8;
	localparam logic [15:0] TAIL_BYTES = 16'd6;
	localparam logic [14:0] LEN_RESET = 15'd8;

	// header byte positions, data byte follows the last one
	localparam logic [2:0] STEP_CMD = 3'd0;
	localparam logic [2:0] STEP_PAD = 3'd1;
	localparam logic [2:0] STEP_ADDR_HI = 3'd2;
	localparam logic [2:0] STEP_ADDR_LO = 3'd3;
	localparam logic [2:0] STEP_LEN_HI = 3'd4;
	localparam logic [2:0] STEP_LEN_LO = 3'd5;
	localparam logic [2:0] STEP_DATA = 3'd6;

	localparam logic REQ_IMAGE = 1'b0;
	localparam logic REQ_CHECK = 1'b1;
	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic result_kind;
		logic [7:0] out_byte;
		logic packet_end;
		logic checksum_ok;
	} rsp_t;

	// one classified item between front and back
	typedef struct packed {
		logic verdict;
		logic ok;
		logic hdr;
		logic last;
		logic [7:0] data;
		logic [15:0] addr;
		logic [15:0] plen;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/fwpf_front.sv =====
// Front end: length register, byte counting, packet classification, running XOR.
// Depends on fwpf_pkg.
`default_nettype none
module fwpf_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [14:0] cfg_wdata,
	input  wire logic req_valid,
	output logic req_ready,
	input  fwpf_pkg::req_t req,
	input  wire logic q_full,
	output logic push,
	output fwpf_pkg::cmd_t push_cmd
);

	logic [14:0] image_length_q;
	logic [14:0] cnt_q;
	logic [fwpf_pkg::POS_W-1:0] pos_q;
	logic [7:0] xor_q;

	logic [14:0] len_eff;
	logic [14:0] body;
	logic [15:0] off;
	logic [15:0] rem;
	logic [15:0] plen;
	logic counted;
	logic in_body;
	logic in_tail;
	logic emit;
	logic accept;

	assign req_ready = ~q_full;
	assign accept = req_valid & req_ready;

	always_comb begin
		len_eff = (image_length_q < fwpf_pkg::TRAILER_BYTES) ? fwpf_pkg::TRAILER_BYTES
			: image_length_q;
		body = len_eff - fwpf_pkg::TRAILER_BYTES;
		counted = (req.req_type == fwpf_pkg::REQ_IMAGE) && (cnt_q < len_eff);
		in_body = cnt_q < body;
		in_tail = ~in_body && ({1'b0, cnt_q} < ({1'b0, body} + fwpf_pkg::TAIL_BYTES));
		emit = counted && (in_body || in_tail);
		off = {1'b0, cnt_q} - 16'(pos_q);
		rem = {1'b0, body} - off;
		plen = (rem > 16'(fwpf_pkg::PACKET_BYTES)) ? 16'(fwpf_pkg::PACKET_BYTES) : rem;

		push_cmd = '0;
		push_cmd.data = req.data_byte;
		if (req.req_type == fwpf_pkg::REQ_CHECK) begin
			push_cmd.verdict = 1'b1;
			push_cmd.ok = (req.data_byte == xor_q);
			push_cmd.data = 8'h00;
		end else if (in_body) begin
			push_cmd.hdr = (pos_q == '0);
			push_cmd.addr = off;
			push_cmd.plen = plen;
			push_cmd.last = (({1'b0, cnt_q} + 16'd1) == (off + plen));
		end else begin
			push_cmd.hdr = 1'b1;
			push_cmd.addr = fwpf_pkg::TAIL_ADDR + ({1'b0, cnt_q} - {1'b0, body});
			push_cmd.plen = 16'd1;
			push_cmd.last = 1'b1;
		end
		push = accept && ((req.req_type == fwpf_pkg::REQ_CHECK) || emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= fwpf_pkg::LEN_RESET;
			cnt_q <= '0;
			pos_q <= '0;
			xor_q <= '0;
		end else begin
			if (cfg_we) begin
				image_length_q <= cfg_wdata;
			end
			if (accept && counted) begin
				cnt_q <= cnt_q + 15'd1;
				pos_q <= (pos_q == fwpf_pkg::POS_W'(fwpf_pkg::PACKET_BYTES - 1)) ? '0
					: pos_q + 1'b1;
				if (emit) begin
					xor_q <= xor_q ^ req.data_byte;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/fwpf_queue.sv =====
// Short command queue between front and back ends.
// Depends on fwpf_pkg.
`default_nettype none
module fwpf_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  fwpf_pkg::cmd_t push_cmd,
	input  wire logic pop,
	output logic full,
	output logic head_valid,
	output fwpf_pkg::cmd_t head
);

	fwpf_pkg::cmd_t slot_q [fwpf_pkg::QUEUE_DEPTH];
	logic [fwpf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fwpf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fwpf_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == fwpf_pkg::QCNT_W'(fwpf_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fwpf_pkg::QPTR_W'(fwpf_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fwpf_pkg::QPTR_W'(fwpf_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/fwpf_back.sv =====
// Back end: expands queued commands into header and data bytes, output register.
// Depends on fwpf_pkg.
`default_nettype none
module fwpf_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  fwpf_pkg::cmd_t head,
	output logic pop,
	output logic rsp_valid,
	input  wire logic rsp_ready,
	output fwpf_pkg::rsp_t rsp
);

	logic [2:0] step_q;
	logic rsp_valid_q;
	fwpf_pkg::rsp_t rsp_q;

	fwpf_pkg::rsp_t nxt;
	logic load;
	logic last;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign load = head_valid && (!rsp_valid_q || rsp_ready);
	assign last = head.verdict || !head.hdr || (step_q == fwpf_pkg::STEP_DATA);
	assign pop = load && last;

	always_comb begin
		nxt = '0;
		if (head.verdict) begin
			nxt.result_kind = fwpf_pkg::KIND_VERDICT;
			nxt.checksum_ok = head.ok;
		end else begin
			nxt.result_kind = fwpf_pkg::KIND_PACKET;
			if (head.hdr) begin
				unique case (step_q)
					fwpf_pkg::STEP_CMD: nxt.out_byte = fwpf_pkg::HDR_CMD;
					fwpf_pkg::STEP_PAD: nxt.out_byte = fwpf_pkg::HDR_PAD;
					fwpf_pkg::STEP_ADDR_HI: nxt.out_byte = head.addr[15:8];
					fwpf_pkg::STEP_ADDR_LO: nxt.out_byte = head.addr[7:0];
					fwpf_pkg::STEP_LEN_HI: nxt.out_byte = head.plen[15:8];
					fwpf_pkg::STEP_LEN_LO: nxt.out_byte = head.plen[7:0];
					default: begin
						nxt.out_byte = head.data;
						nxt.packet_end = head.last;
					end
				endcase
			end else begin
				nxt.out_byte = head.data;
				nxt.packet_end = head.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fwpf_pkg::STEP_CMD;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= last ? fwpf_pkg::STEP_CMD : step_q + 3'd1;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/firmware_image_packet_framer_unit.sv =====
// Firmware image packet framer, top level.
// Depends on fwpf_pkg, fwpf_front, fwpf_queue, fwpf_back.
//
// Usage:
//   req channel (req_valid/req_ready/req): image bytes (req_type 0) or a
//   read-back checksum byte (req_type 1). rsp channel (rsp_valid/rsp_ready/rsp):
//   packet bytes with packet_end on the last byte, or a checksum verdict.
//   cfg_we/cfg_wdata write image_length; write only while the block is idle.
// Path: the first result of an item is written into the command queue and
//   then into the back end's output register, from which it is presented.
// Throughput: one output byte per cycle while rsp_ready is high, set by the back
//   end's single output register. A byte without header gives one output byte; a
//   byte that opens a packet expands to 7 output bytes and holds the back end until
//   all are out, while the 2-entry command queue keeps taking input until it fills.
// Reset: arst_n clears the byte count, running XOR and queue, and sets
//   image_length to 8.
// Stall: when rsp_ready is low the output holds; the queue fills and then
//   req_ready drops. No data is lost or repeated.
`default_nettype none
module firmware_image_packet_framer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [14:0] cfg_wdata,
	input  wire logic req_valid,
	output logic req_ready,
	input  fwpf_pkg::req_t req,
	output logic rsp_valid,
	input  wire logic rsp_ready,
	output fwpf_pkg::rsp_t rsp
);

	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	fwpf_pkg::cmd_t push_cmd;
	fwpf_pkg::cmd_t head;

	fwpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	fwpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	fwpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ===== test/tb_firmware_image_packet_framer_unit.sv =====
// Testbench for firmware_image_packet_framer_unit: feeds image bytes and checksum reads
// under random sender gaps and output stalls, and checks every packet byte and verdict.
// Depends on fwpf_pkg and the top level in design/.
module tb_firmware_image_packet_framer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fwpf_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 80;
	localparam int WATCHDOG_CYCLES = 300000;
	localparam int REPORT_LIMIT = 10;

	typedef enum int {RX_STREAM, RX_BUSY, RX_COMB, RX_SPARSE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [14:0] cfg_wdata;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	bit hold_armed = 1'b0;

	firmware_image_packet_framer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Tracks image position and XOR, and holds the framed bytes still to come out.
	class frame_tracker;
		logic [14:0] image_length;
		logic [14:0] byte_count;
		logic [7:0] running_xor;
		rsp_t framed_q[$];
		int errors;
		int reported;
		int n_framed;
		int n_checks;
		int n_bytes;
		int n_packets;

		function new();
			image_length = LEN_RESET;
			byte_count = '0;
			running_xor = '0;
			errors = 0;
			reported = 0;
			n_framed = 0;
			n_checks = 0;
			n_bytes = 0;
			n_packets = 0;
		endfunction

		function void push_byte(logic kind, logic [7:0] b, logic pend, logic ok);
			framed_q.push_back(rsp_t'{kind, b, pend, ok});
		endfunction

		function void push_header(logic [15:0] addr, logic [15:0] plen);
			push_byte(KIND_PACKET, HDR_CMD, 1'b0, 1'b0);
			push_byte(KIND_PACKET, HDR_PAD, 1'b0, 1'b0);
			push_byte(KIND_PACKET, addr[15:8], 1'b0, 1'b0);
			push_byte(KIND_PACKET, addr[7:0], 1'b0, 1'b0);
			push_byte(KIND_PACKET, plen[15:8], 1'b0, 1'b0);
			push_byte(KIND_PACKET, plen[7:0], 1'b0, 1'b0);
		endfunction

		function void frame_request(req_t r);
			int len_eff;
			int body;
			int c;
			int off;
			int plen;
			if (r.req_type == REQ_CHECK) begin
				n_checks++;
				push_byte(KIND_VERDICT, 8'h00, 1'b0, r.data_byte == running_xor);
				return;
			end
			len_eff = (image_length < TRAILER_BYTES) ? int'(TRAILER_BYTES) : int'(image_length);
			if (int'(byte_count) >= len_eff)
				return;
			n_framed++;
			body = len_eff - int'(TRAILER_BYTES);
			c = int'(byte_count);
			byte_count = byte_count + 15'd1;
			if (c < body) begin
				off = c - (c % PACKET_BYTES);
				plen = (body - off > PACKET_BYTES) ? PACKET_BYTES : body - off;
				if (c == off)
					push_header(16'(off), 16'(plen));
				push_byte(KIND_PACKET, r.data_byte, c + 1 == off + plen, 1'b0);
				running_xor ^= r.data_byte;
			end else if (c < body + int'(TAIL_BYTES)) begin
				push_header(TAIL_ADDR + 16'(c - body), 16'd1);
				push_byte(KIND_PACKET, r.data_byte, 1'b1, 1'b0);
				running_xor ^= r.data_byte;
			end
			// last two image bytes: counted only
		endfunction

		function void check_output(rsp_t got);
			rsp_t want;
			if (framed_q.size() == 0) begin
				errors++;
				if (reported < REPORT_LIMIT)
					$display("%0t: unexpected result kind=%0d byte=%02h end=%0d ok=%0d",
						$time, got.result_kind, got.out_byte, got.packet_end, got.checksum_ok);
				reported++;
				return;
			end
			want = framed_q.pop_front();
			if (got.result_kind == KIND_PACKET) begin
				n_bytes++;
				if (got.packet_end)
					n_packets++;
			end
			if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
					got.packet_end !== want.packet_end || got.checksum_ok !== want.checksum_ok) begin
				errors++;
				if (reported < REPORT_LIMIT)
					$display("%0t: mismatch kind/byte/end/ok exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
						$time, want.result_kind, want.out_byte, want.packet_end, want.checksum_ok,
						got.result_kind, got.out_byte, got.packet_end, got.checksum_ok);
				reported++;
			end
		endfunction
	endclass

	frame_tracker tracker;

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_output(rsp);
	end

	// Receiver: random stall segments, plus one long hold-off once armed.
	initial begin
		int seg_left;
		int hold_left;
		bit hold_done;
		rx_mode_e mode;
		seg_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		mode = RX_STREAM;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				rsp_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_e'($urandom_range(3));
					seg_left = $urandom_range(16, 64);
				end
				seg_left--;
				case (mode)
					RX_STREAM: rsp_ready <= 1'b1;
					RX_BUSY: rsp_ready <= ($urandom_range(3) != 0);
					RX_COMB: rsp_ready <= (seg_left % 3 != 0);
					default: rsp_ready <= ($urandom_range(9) < 3);
				endcase
			end
		end
	end

	task automatic send_req(input req_t item);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		tracker.frame_request(item);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (tracker.framed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [14:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.image_length = value;
	endtask

	initial begin
		logic [7:0] corner_bytes[9];
		int phase_len[5];
		int phase_images[5];
		int images_sent;
		int burst_left;
		int gap;
		req_t item;
		corner_bytes = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h3c};
		phase_len = '{140, 28674, 190, 32767, 3};
		phase_images = '{145, 30, 22, 8, 4};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length: empty body, six tail packets, two dropped, one past the end
		send_req(req_t'{REQ_CHECK, 8'h00});
		send_req(req_t'{REQ_CHECK, 8'hff});
		foreach (corner_bytes[i])
			send_req(req_t'{REQ_IMAGE, corner_bytes[i]});
		send_req(req_t'{REQ_CHECK, tracker.running_xor});
		send_req(req_t'{REQ_CHECK, ~tracker.running_xor});

		// lengths below the minimum
		write_length(15'd0);
		send_req(req_t'{REQ_IMAGE, 8'ha5});
		send_req(req_t'{REQ_CHECK, tracker.running_xor});
		write_length(15'd5);
		send_req(req_t'{REQ_IMAGE, 8'h5a});
		send_req(req_t'{REQ_CHECK, 8'h00});

		for (int p = 0; p < 5; p++) begin
			write_length(15'(phase_len[p]));
			if (p == 0)
				hold_armed = 1'b1;
			images_sent = 0;
			burst_left = 0;
			while (images_sent < phase_images[p]) begin
				if (burst_left == 0) begin
					gap = $urandom_range(0, 6);
					if (gap > 0) begin
						req_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
				end
				burst_left--;
				if ($urandom_range(99) < 8) begin
					item.req_type = REQ_CHECK;
					item.data_byte = $urandom_range(1) ? tracker.running_xor : 8'($urandom);
				end else begin
					item.req_type = REQ_IMAGE;
					item.data_byte = 8'($urandom);
					images_sent++;
				end
				send_req(item);
			end
		end

		wait_idle();
		$display("Framed %0d image bytes into %0d packets (%0d packet bytes), %0d checksum reads",
			tracker.n_framed, tracker.n_packets, tracker.n_bytes, tracker.n_checks);
		$display("Lengths: reset, below minimum, multi-packet, mid-stream changes, full range");
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(WATCHDOG_CYCLES * 2 * CLK_HALF);
		$display("FAIL");
		$finish;
	end

endmodule

// ===== firmware_image_packet_framer_unit.f =====
design/fwpf_pkg.sv
design/fwpf_front.sv
design/fwpf_queue.sv
design/fwpf_back.sv
design/firmware_image_packet_framer_unit.sv
test/tb_firmware_image_packet_framer_unit.sv
